// ===== sv/wbr_pkg.sv =====
// Package for the waveform bank registry: sizes, codes and shared types.
`default_nettype none
package wbr_pkg;

  localparam int FACTORY_SLOTS = 64;
  localparam int USER_BOARDS   = 2;
  localparam int USER_ENTRIES  = 64;

  localparam int NBANK      = USER_BOARDS + 1;
  localparam int BANK_DEPTH = (FACTORY_SLOTS > USER_ENTRIES) ? FACTORY_SLOTS : USER_ENTRIES;
  localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(BANK_DEPTH + 1);
  localparam int CELL_W     = $clog2(NBANK);
  localparam int USED_W     = 40;
  localparam int KEY_MAX    = 127;
  localparam int DRAIN_CYC  = NBANK + 2;
  localparam int DRN_W      = $clog2(DRAIN_CYC + 1);

  typedef enum logic [1:0] {
    CMD_ADD_FACTORY = 2'd0,
    CMD_ADD_USER    = 2'd1,
    CMD_FIND        = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_BOARD  = 3'd1,
    STAT_SLOTS_FULL = 3'd2,
    STAT_INVALID    = 3'd3,
    STAT_NO_SPACE   = 3'd4,
    STAT_DUPLICATE  = 3'd5,
    STAT_NOT_FOUND  = 3'd6
  } status_e;

  typedef enum logic {
    REG_FACTORY_CAP = 1'b0,
    REG_BOARD_CAP   = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_REPORT
  } state_e;

  typedef struct packed {
    logic signed [15:0] id;
    logic [31:0]        bytes;
    logic [6:0]         root;
    logic [6:0]         klo;
    logic [6:0]         khi;
    logic [6:0]         vlo;
    logic [6:0]         vhi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // search result handed down the row of bank cells
  typedef struct packed {
    logic              hit;
    logic [CELL_W-1:0] bank;
    entry_t            entry;
  } token_t;

  // controls shared by all bank cells
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic signed [15:0] id;
    entry_t             wr_data;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/wbr_ram.sv =====
// Generic single-write, registered-read RAM.
`default_nettype none
module wbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/wbr_cell.sv =====
// One bank cell: entry store, count, used bytes, scan compare and token stage.
`default_nettype none
module wbr_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [wbr_pkg::CELL_W-1:0] bank_i,
  input  wire wbr_pkg::cell_ctl_t ctl_i,
  input  wire logic               search_en_i,
  input  wire logic               wr_en_i,
  input  wire wbr_pkg::token_t    tok_i,
  output wbr_pkg::token_t         tok_o,
  output logic [wbr_pkg::CNT_W-1:0]  count_o,
  output logic [wbr_pkg::USED_W-1:0] used_o
);
  import wbr_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [USED_W-1:0] used_q, used_d;
  logic [USED_W:0]   sum;
  logic              cmp_q, cmp_d;
  logic              hit_q;
  entry_t            hit_entry_q, rd_entry;
  logic [ENTRY_W-1:0] rdata;
  token_t            tok_q, tok_d;

  wbr_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ctl_i.wr_data),
    .raddr_i (ctl_i.rd_addr),
    .rdata_o (rdata)
  );

  assign rd_entry = rdata;
  // only entries below the fill count take part
  assign cmp_d = ctl_i.rd_en && search_en_i && (CNT_W'(ctl_i.rd_addr) < count_q);

  assign sum    = {1'b0, used_q} + (USED_W + 1)'(ctl_i.wr_data.bytes);
  assign used_d = sum[USED_W] ? {USED_W{1'b1}} : sum[USED_W-1:0];

  // an earlier bank's hit wins
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && hit_q) begin
      tok_d.hit   = 1'b1;
      tok_d.bank  = bank_i;
      tok_d.entry = hit_entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      used_q  <= '0;
      cmp_q   <= 1'b0;
      hit_q   <= 1'b0;
      tok_q   <= '0;
    end else begin
      cmp_q <= cmp_d;
      tok_q <= tok_d;
      if (ctl_i.clear) begin
        hit_q <= 1'b0;
      end else if (cmp_q && !hit_q && rd_entry.id == ctl_i.id) begin
        hit_q <= 1'b1;
      end
      if (wr_en_i) begin
        count_q <= count_q + CNT_W'(1);
        used_q  <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctl_i.clear && cmp_q && !hit_q && rd_entry.id == ctl_i.id) begin
      hit_entry_q <= rd_entry;
    end
  end

  assign tok_o   = tok_q;
  assign count_o = count_q;
  assign used_o  = used_q;
endmodule
`default_nettype wire

// ===== sv/waveform_bank_registry.sv =====
// Top level of the waveform bank registry: stream ports, APB registers, control.
// One item at a time: a new input transfer is taken only back in idle, after the result
// of the last item is loaded, which waits while the result stream is held. The item time is
// set by the entry scan of one bank store read per cycle (all banks scan side by side)
// plus the token row. Reset clears counts, used bytes and both capacities; entry
// stores are not cleared, only entries below a bank's count are ever read.
`default_nettype none
module waveform_bank_registry (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // board[2:0] entry_id[18:3] has_name[19] size_bytes[51:20] root_note[60:52]
  // low_note[69:61] high_note[78:70] low_velocity[87:79] high_velocity[96:88]
  input  wire logic [103:0] s_axis_tdata_i,
  // cmd[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  // result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // found_bank[1:0] found_bytes[33:2] found_root[40:34] found_key_low[47:41]
  // found_key_high[54:48] found_vel_low[61:55] found_vel_high[68:62]
  // board_count[75:69] board_used[115:76]
  output logic [119:0]      m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]        m_axis_tuser_o,
  // configuration
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [2:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);
  import wbr_pkg::*;

  // ---------------- configuration registers ----------------
  logic [31:0] fac_cap_q, brd_cap_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign prdata_o = (reg_e'(paddr_i[2]) == REG_BOARD_CAP) ? brd_cap_q : fac_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fac_cap_q <= '0;
      brd_cap_q <= '0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr_i[2]))
        REG_FACTORY_CAP: fac_cap_q <= pwdata_i;
        REG_BOARD_CAP:   brd_cap_q <= pwdata_i;
        default:         fac_cap_q <= fac_cap_q;
      endcase
    end
  end

  // ---------------- latched input item ----------------
  cmd_e               cmd_q;
  logic signed [2:0]  board_q;
  logic signed [15:0] id_q;
  logic               name_q;
  logic [31:0]        size_q;
  logic signed [8:0]  root_q, klo_q, khi_q, vlo_q, vhi_q;

  // ---------------- control ----------------
  state_e           state_q, state_d;
  logic [IDX_W-1:0] scan_q;
  logic [DRN_W-1:0] drain_q;
  logic             in_xfer, out_load;
  status_e          res_q, res_d;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_SCAN;
      ST_SCAN:   if (scan_q == IDX_W'(BANK_DEPTH - 1)) state_d = ST_DRAIN;
      ST_DRAIN:  if (drain_q == DRN_W'(DRAIN_CYC - 1)) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_REPORT;
      ST_REPORT: begin
        if (!m_axis_tvalid_o || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- bank cells ----------------
  cell_ctl_t         ctl;
  logic [NBANK-1:0]  search_en, wr_en;
  token_t            tok [NBANK+1];
  logic [CNT_W-1:0]  cnt  [NBANK];
  logic [USED_W-1:0] used [NBANK];

  logic              is_find, board_ok, commit_ok;
  logic [CELL_W-1:0] tgt, rep;

  assign is_find  = !(cmd_q == CMD_ADD_FACTORY || cmd_q == CMD_ADD_USER);
  assign board_ok = !board_q[2] && (32'(board_q[1:0]) < USER_BOARDS);
  assign rep      = CELL_W'({1'b0, board_q[1:0]}) + CELL_W'(1);
  assign tgt      = (cmd_q == CMD_ADD_FACTORY) ? '0 : rep;

  assign ctl.clear           = in_xfer;
  assign ctl.rd_en           = (state_q == ST_SCAN);
  assign ctl.rd_addr         = scan_q;
  assign ctl.id              = id_q;
  assign ctl.wr_data.id      = id_q;
  assign ctl.wr_data.bytes   = size_q;
  assign ctl.wr_data.root    = root_q[6:0];
  assign ctl.wr_data.klo     = klo_q[6:0];
  assign ctl.wr_data.khi     = khi_q[6:0];
  assign ctl.wr_data.vlo     = vlo_q[6:0];
  assign ctl.wr_data.vhi     = vhi_q[6:0];

  assign tok[0] = '0;

  for (genvar k = 0; k < NBANK; k++) begin : g_cell
    // find scans every bank, an add only its own bank for duplicates
    assign search_en[k] = is_find ||
                          (cmd_q == CMD_ADD_FACTORY && k == 0) ||
                          (cmd_q == CMD_ADD_USER && board_ok && tgt == CELL_W'(k));
    assign wr_en[k] = (state_q == ST_COMMIT) && commit_ok && (tgt == CELL_W'(k));

    wbr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bank_i      (CELL_W'(k)),
      .ctl_i       (ctl),
      .search_en_i (search_en[k]),
      .wr_en_i     (wr_en[k]),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1]),
      .count_o     (cnt[k]),
      .used_o      (used[k])
    );
  end

  // ---------------- add checks ----------------
  logic              valid_desc, over_budget;
  logic [31:0]       cap;
  logic [USED_W-1:0] tgt_used, remain;
  logic [CNT_W-1:0]  tgt_cnt;

  assign tgt_used = used[tgt];
  assign tgt_cnt  = cnt[tgt];
  assign cap      = (cmd_q == CMD_ADD_FACTORY) ? fac_cap_q : brd_cap_q;
  assign remain   = (tgt_used >= USED_W'(cap)) ? '0 : USED_W'(cap) - tgt_used;
  assign over_budget = (cap != '0) && (USED_W'(size_q) > remain);

  assign valid_desc = (id_q > 16'sd0) && name_q && (size_q != '0) &&
                      (root_q >= 9'sd0) && (root_q <= 9'(KEY_MAX)) &&
                      (klo_q >= 9'sd0) && (khi_q <= 9'(KEY_MAX)) && (klo_q <= khi_q) &&
                      (vlo_q >= 9'sd1) && (vhi_q <= 9'(KEY_MAX)) && (vlo_q <= vhi_q);

  always_comb begin
    res_d = STAT_OK;
    if (is_find) begin
      res_d = tok[NBANK].hit ? STAT_OK : STAT_NOT_FOUND;
    end else if (cmd_q == CMD_ADD_FACTORY && 32'(tgt_cnt) >= FACTORY_SLOTS) begin
      res_d = STAT_SLOTS_FULL;
    end else if (cmd_q == CMD_ADD_USER && !board_ok) begin
      res_d = STAT_BAD_BOARD;
    end else if (!valid_desc) begin
      res_d = STAT_INVALID;
    end else if (over_budget) begin
      res_d = STAT_NO_SPACE;
    end else if (cmd_q == CMD_ADD_USER && 32'(tgt_cnt) >= USER_ENTRIES) begin
      res_d = STAT_NO_SPACE;
    end else if (tok[NBANK].hit) begin
      res_d = STAT_DUPLICATE;
    end
  end

  assign commit_ok = !is_find && (res_d == STAT_OK);

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      scan_q          <= '0;
      drain_q         <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + IDX_W'(1);
      end else begin
        scan_q <= '0;
      end
      if (state_q == ST_DRAIN) begin
        drain_q <= drain_q + DRN_W'(1);
      end else begin
        drain_q <= '0;
      end
      if (out_load) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  logic [31:0] cnt_ext;
  token_t      fin;
  logic        show;

  assign fin     = tok[NBANK];
  assign show    = is_find && fin.hit;
  assign cnt_ext = 32'(cnt[rep]);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_e'(s_axis_tuser_i);
      board_q <= s_axis_tdata_i[2:0];
      id_q    <= s_axis_tdata_i[18:3];
      name_q  <= s_axis_tdata_i[19];
      size_q  <= s_axis_tdata_i[51:20];
      root_q  <= s_axis_tdata_i[60:52];
      klo_q   <= s_axis_tdata_i[69:61];
      khi_q   <= s_axis_tdata_i[78:70];
      vlo_q   <= s_axis_tdata_i[87:79];
      vhi_q   <= s_axis_tdata_i[96:88];
    end
    if (state_q == ST_COMMIT) begin
      res_q <= res_d;
    end
    // board report is taken after the commit write has landed
    if (out_load) begin
      m_axis_tuser_o          <= res_q;
      m_axis_tdata_o[1:0]     <= show ? 2'(fin.bank) : 2'd0;
      m_axis_tdata_o[33:2]    <= show ? fin.entry.bytes : 32'd0;
      m_axis_tdata_o[40:34]   <= show ? fin.entry.root : 7'd0;
      m_axis_tdata_o[47:41]   <= show ? fin.entry.klo : 7'd0;
      m_axis_tdata_o[54:48]   <= show ? fin.entry.khi : 7'd0;
      m_axis_tdata_o[61:55]   <= show ? fin.entry.vlo : 7'd0;
      m_axis_tdata_o[68:62]   <= show ? fin.entry.vhi : 7'd0;
      m_axis_tdata_o[75:69]   <= board_ok ? cnt_ext[6:0] : 7'd0;
      m_axis_tdata_o[115:76]  <= board_ok ? used[rep] : '0;
      m_axis_tdata_o[119:116] <= 4'd0;
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb_waveform_bank_registry.sv =====
// Self-checking testbench for the waveform bank registry: directed and random transfers.
`timescale 1ns / 100ps
module tb_waveform_bank_registry;
  import wbr_pkg::*;

  localparam int  STALL_LEN  = 300;   // long receiver hold-off for the pressure test
  localparam int  WDOG_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int  SETTLE_CYC = 100;   // settle wait after the last answer in wait_idle
  localparam logic [39:0] USED_SAT = 40'hFF_FFFF_FFFF;

  // one registry command as seen on the input stream
  typedef struct {
    cmd_e               cmd;
    logic signed [2:0]  board;
    logic signed [15:0] id;
    logic               has_name;
    logic [31:0]        size;
    logic signed [8:0]  root, klo, khi, vlo, vhi;
  } wave_cmd_t;

  // one registry answer as expected on the result stream
  typedef struct {
    status_e     status;
    logic [1:0]  bank;
    logic [31:0] bytes;
    logic [6:0]  root, klo, khi, vlo, vhi;
    logic [6:0]  count;
    logic [39:0] used;
  } wave_ans_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [103:0]  s_axis_tdata_i = '0;   // board, entry_id, has_name, size_bytes, root_note,
                                        // low_note, high_note, low_velocity, high_velocity
  logic [1:0]    s_axis_tuser_i = '0;   // cmd
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [119:0]  m_axis_tdata_o;        // found_bank, found_bytes, found_root, found_key_low,
                                        // found_key_high, found_vel_low, found_vel_high,
                                        // board_count, board_used
  logic [2:0]    m_axis_tuser_o;        // status
  logic          psel_i = 1'b0;
  logic          penable_i = 1'b0;
  logic          pwrite_i = 1'b0;
  logic [2:0]    paddr_i = '0;
  logic [31:0]   pwdata_i = '0;
  logic [31:0]   prdata_o;
  logic          pready_o;

  always #2 clk_i = ~clk_i;

  waveform_bank_registry u_dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow registry: our own copy of banks, counts, used bytes and budgets
  // ---------------------------------------------------------------------------
  entry_t      shadow_store [NBANK][BANK_DEPTH];
  int          shadow_count [NBANK];
  logic [39:0] shadow_used  [NBANK];
  logic [31:0] factory_cap, board_cap;

  wave_ans_t answer_q[$];
  int        mismatches, n_cmds, n_answers, n_hits, n_adds_ok;
  int        src_idle_pct, snk_idle_pct;
  bit        stall_req;

  function automatic int bank_lookup(int b, logic signed [15:0] id);
    for (int i = 0; i < shadow_count[b]; i++)
      if (shadow_store[b][i].id == id) return i;
    return -1;
  endfunction

  function automatic status_e bank_append(int b, logic [31:0] cap, int limit, wave_cmd_t c);
    int r, kl, kh, vl, vh;
    logic [63:0] room, sum;
    entry_t e;
    r = c.root; kl = c.klo; kh = c.khi; vl = c.vlo; vh = c.vhi;
    if (!(c.id > 0 && c.has_name && c.size != 0 && r >= 0 && r <= KEY_MAX &&
          kl >= 0 && kh <= KEY_MAX && kl <= kh && vl >= 1 && vh <= KEY_MAX && vl <= vh))
      return STAT_INVALID;
    if (cap != 0) begin
      room = (shadow_used[b] >= cap) ? 64'd0 : 64'(cap) - 64'(shadow_used[b]);
      if (64'(c.size) > room) return STAT_NO_SPACE;
    end
    if (shadow_count[b] >= limit) return STAT_NO_SPACE;  // entry store full
    if (bank_lookup(b, c.id) >= 0) return STAT_DUPLICATE;
    e.id = c.id; e.bytes = c.size;
    e.root = c.root[6:0]; e.klo = c.klo[6:0]; e.khi = c.khi[6:0];
    e.vlo = c.vlo[6:0]; e.vhi = c.vhi[6:0];
    shadow_store[b][shadow_count[b]] = e;
    shadow_count[b]++;
    sum = 64'(shadow_used[b]) + 64'(c.size);
    shadow_used[b] = (sum > 64'(USED_SAT)) ? USED_SAT : sum[39:0];
    return STAT_OK;
  endfunction

  // applies one command to the shadow registry and returns the answer it must give
  function automatic wave_ans_t registry_apply(wave_cmd_t c);
    wave_ans_t a;
    int bd, idx;
    bit bd_ok;
    a = '{status: STAT_NOT_FOUND, default: '0};
    bd = c.board;
    bd_ok = bd >= 0 && bd < USER_BOARDS;
    if (c.cmd == CMD_ADD_FACTORY) begin
      if (shadow_count[0] >= FACTORY_SLOTS) a.status = STAT_SLOTS_FULL;
      else a.status = bank_append(0, factory_cap, FACTORY_SLOTS, c);
    end else if (c.cmd == CMD_ADD_USER) begin
      if (!bd_ok) a.status = STAT_BAD_BOARD;
      else a.status = bank_append(bd + 1, board_cap, USER_ENTRIES, c);
    end else begin
      // find, also for the unused command code
      for (int b = 0; b < NBANK; b++) begin
        idx = bank_lookup(b, c.id);
        if (idx >= 0) begin
          a.status = STAT_OK;
          a.bank = 2'(b);
          a.bytes = shadow_store[b][idx].bytes;
          a.root = shadow_store[b][idx].root;
          a.klo = shadow_store[b][idx].klo;
          a.khi = shadow_store[b][idx].khi;
          a.vlo = shadow_store[b][idx].vlo;
          a.vhi = shadow_store[b][idx].vhi;
          break;
        end
      end
    end
    if (bd_ok) begin
      a.count = 7'(shadow_count[bd + 1]);
      a.used = shadow_used[bd + 1];
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH @%0t result %0d %s: expected %0h got %0h",
             $realtime, n_answers, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    wave_ans_t w;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result transfer", 0, m_axis_tuser_o);
      end else begin
        w = answer_q.pop_front();
        if (m_axis_tuser_o != w.status) report_mismatch("status", w.status, m_axis_tuser_o);
        if (m_axis_tdata_o[1:0] != w.bank) report_mismatch("found_bank", w.bank,
                                                           m_axis_tdata_o[1:0]);
        if (m_axis_tdata_o[33:2] != w.bytes) report_mismatch("found_bytes", w.bytes,
                                                             m_axis_tdata_o[33:2]);
        if (m_axis_tdata_o[40:34] != w.root) report_mismatch("found_root", w.root,
                                                             m_axis_tdata_o[40:34]);
        if (m_axis_tdata_o[47:41] != w.klo) report_mismatch("found_key_low", w.klo,
                                                            m_axis_tdata_o[47:41]);
        if (m_axis_tdata_o[54:48] != w.khi) report_mismatch("found_key_high", w.khi,
                                                            m_axis_tdata_o[54:48]);
        if (m_axis_tdata_o[61:55] != w.vlo) report_mismatch("found_vel_low", w.vlo,
                                                            m_axis_tdata_o[61:55]);
        if (m_axis_tdata_o[68:62] != w.vhi) report_mismatch("found_vel_high", w.vhi,
                                                            m_axis_tdata_o[68:62]);
        if (m_axis_tdata_o[75:69] != w.count) report_mismatch("board_count", w.count,
                                                              m_axis_tdata_o[75:69]);
        if (m_axis_tdata_o[115:76] != w.used) report_mismatch("board_used", w.used,
                                                              m_axis_tdata_o[115:76]);
        if (w.status == STAT_OK && w.bytes != 0) n_hits++;
      end
      n_answers++;
    end
  end

  // receiver: random tready, or a long hold-off when the pressure test asks for one
  always @(posedge clk_i) begin
    int hold_left;
    if (stall_req) begin
      hold_left = STALL_LEN;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog: counts cycles with no transfer on either stream and no APB select
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        psel_i)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
      $display("waveform_bank_registry test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(reg_e r, logic [31:0] value);
    @(posedge clk_i);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= 3'(int'(r) * 4); pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);  // register written at this edge
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    if (r == REG_FACTORY_CAP) factory_cap = value;
    else board_cap = value;
  endtask

  // one command transfer; tvalid stays high when the next command follows without a gap
  task automatic send_cmd(wave_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= c.cmd;
    s_axis_tdata_i  <= {7'd0, c.vhi, c.vlo, c.khi, c.klo, c.root, c.size, c.has_name,
                        c.id, c.board};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    answer_q.insert(answer_q.size(), registry_apply(c));
    n_cmds++;
  endtask

  // block idle: every answer in, then room for a command that is still in flight
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Command builders
  // ---------------------------------------------------------------------------
  function automatic wave_cmd_t good_cmd(cmd_e op, int board, int id, int size);
    wave_cmd_t c;
    int lo, vl;
    lo = $urandom_range(127);
    vl = $urandom_range(1, 127);
    c.cmd = op; c.board = 3'(board); c.id = 16'(id); c.has_name = 1'b1;
    c.size = size;
    c.root = 9'($urandom_range(127));
    c.klo = 9'(lo); c.khi = 9'($urandom_range(lo, 127));
    c.vlo = 9'(vl); c.vhi = 9'($urandom_range(vl, 127));
    return c;
  endfunction

  // raw bits in every field, including the unused command code
  function automatic wave_cmd_t noise_cmd();
    wave_cmd_t c;
    c.cmd = cmd_e'($urandom_range(3));
    c.board = 3'($urandom); c.id = 16'($urandom); c.has_name = 1'($urandom);
    c.size = $urandom;
    c.root = 9'($urandom); c.klo = 9'($urandom); c.khi = 9'($urandom);
    c.vlo = 9'($urandom); c.vhi = 9'($urandom);
    return c;
  endfunction

  // mostly well-formed commands on a small id pool so finds hit and duplicates occur
  function automatic wave_cmd_t random_cmd();
    wave_cmd_t c;
    int pick, size;
    pick = $urandom_range(99);
    size = ($urandom_range(9) == 0) ? int'($urandom) : $urandom_range(1, 300);
    if (pick < 10) return noise_cmd();
    c = good_cmd(cmd_e'($urandom_range(2)), $urandom_range(9) == 0 ? $urandom_range(2, 7)
                 : $urandom_range(1), $urandom_range(1, 160), size);
    if (pick < 25) begin
      // one broken field
      case ($urandom_range(5))
        0: c.id = -16'($urandom_range(32768));
        1: c.has_name = 1'b0;
        2: c.size = '0;
        3: c.root = 9'($urandom_range(128, 511));
        4: begin c.klo = 9'd100; c.khi = 9'd20; end
        default: c.vlo = 9'd0;
      endcase
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_and_registers();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_FACTORY_CAP, 32'd0);
    write_reg(REG_BOARD_CAP, 32'd0);
  endtask

  task automatic test_directed();
    wave_cmd_t c;
    // extremes that must be accepted
    send_cmd(good_cmd(CMD_ADD_FACTORY, 0, 32767, 32'hFFFF_FFFF));
    c = good_cmd(CMD_ADD_USER, 0, 1, 1);
    c.root = 9'd127; c.klo = 9'd0; c.khi = 9'd127; c.vlo = 9'd1; c.vhi = 9'd127;
    send_cmd(c);
    send_cmd(good_cmd(CMD_ADD_USER, 1, 500, 32'hFFFF_FFFF));
    send_cmd(good_cmd(CMD_ADD_USER, 1, 500, 7));      // duplicate in same bank
    send_cmd(good_cmd(CMD_ADD_USER, 0, 500, 7));      // same id in another bank is fine
    // bad board indexes
    send_cmd(good_cmd(CMD_ADD_USER, -2, 9, 9));
    send_cmd(good_cmd(CMD_ADD_USER, -1, 9, 9));
    send_cmd(good_cmd(CMD_ADD_USER, 2, 9, 9));
    send_cmd(good_cmd(CMD_ADD_USER, 3, 9, 9));
    // invalid descriptors, one rule at a time
    send_cmd(good_cmd(CMD_ADD_FACTORY, 0, 0, 5));
    send_cmd(good_cmd(CMD_ADD_FACTORY, 0, -32768, 5));
    c = good_cmd(CMD_ADD_FACTORY, 0, 20, 5); c.has_name = 1'b0; send_cmd(c);
    send_cmd(good_cmd(CMD_ADD_FACTORY, 0, 21, 0));
    c = good_cmd(CMD_ADD_FACTORY, 0, 22, 5); c.root = -9'sd128; send_cmd(c);
    c = good_cmd(CMD_ADD_FACTORY, 0, 23, 5); c.root = 9'd255; send_cmd(c);
    c = good_cmd(CMD_ADD_FACTORY, 0, 24, 5); c.klo = -9'sd1; send_cmd(c);
    c = good_cmd(CMD_ADD_USER, 1, 25, 5); c.klo = 9'd60; c.khi = 9'd59; send_cmd(c);
    c = good_cmd(CMD_ADD_USER, 1, 26, 5); c.khi = 9'd128; send_cmd(c);
    c = good_cmd(CMD_ADD_USER, 0, 27, 5); c.vlo = 9'd0; send_cmd(c);
    c = good_cmd(CMD_ADD_USER, 0, 28, 5); c.vhi = 9'd128; send_cmd(c);
    c = good_cmd(CMD_ADD_USER, 0, 29, 5); c.vlo = 9'd90; c.vhi = 9'd80; send_cmd(c);
    // finds: factory hit, user hits, miss, unused code, board report off-range
    send_cmd(good_cmd(CMD_FIND, 1, 32767, 0));
    send_cmd(good_cmd(CMD_FIND, 0, 1, 0));
    send_cmd(good_cmd(CMD_FIND, -1, 500, 0));
    send_cmd(good_cmd(CMD_FIND, 1, 12345, 0));
    c = good_cmd(CMD_FIND, 0, 500, 0); c.cmd = cmd_e'(2'd3); send_cmd(c);
  endtask

  task automatic test_random(int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  // receiver holds off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    stall_req = 1'b1;
    repeat (8) send_cmd(random_cmd());
  endtask

  // sender waits for every answer, then fires a burst
  task automatic test_pause_then_burst();
    s_axis_tvalid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    test_random(20);
  endtask

  initial begin
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int b = 0; b < NBANK; b++) begin
      shadow_count[b] = 0;
      shadow_used[b] = '0;
    end
    factory_cap = '0;
    board_cap = '0;

    test_reset_and_registers();
    test_directed();

    // sender idles often, receiver more often; tight factory budget
    src_idle_pct = 34; snk_idle_pct = 45;
    wait_idle();
    write_reg(REG_FACTORY_CAP, 32'd1000);
    write_reg(REG_BOARD_CAP, 32'hFFFF_FFFF);
    test_random(420);

    // roles swapped; board budget at the minimum, factory at the maximum
    src_idle_pct = 45; snk_idle_pct = 34;
    wait_idle();
    write_reg(REG_FACTORY_CAP, 32'hFFFF_FFFF);
    write_reg(REG_BOARD_CAP, 32'd1);
    test_random(400);

    // no idling; unlimited budgets so the stores fill to the slot limits
    src_idle_pct = 0; snk_idle_pct = 0;
    wait_idle();
    write_reg(REG_FACTORY_CAP, 32'd0);
    write_reg(REG_BOARD_CAP, 32'd0);
    test_backpressure();
    test_pause_then_burst();
    test_random(420);

    wait_idle();
    $display("covered %0d commands, %0d results, %0d find hits; banks hold %0d/%0d/%0d entries",
             n_cmds, n_answers, n_hits, shadow_count[0], shadow_count[1], shadow_count[2]);
    $display("budgets exercised at zero, one, small and maximum; %0d mismatches", mismatches);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("waveform_bank_registry test passed");
    end else begin
      $display("waveform_bank_registry test failed");
    end
    $finish;
  end

endmodule
